// File: sv/rspe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, configuration register codes, state codes and cell control
// struct for the Reed-Solomon parity encoder. No dependencies.
package rspe_pkg;

	// Parameter defaults
	localparam int SYM_BITS_DEF = 12;
	localparam int PARITY_DEF   = 64;

	// Configuration register widths
	localparam int SW_BITS       = 4;
	localparam int POLY_BITS     = 13;
	localparam int BASE_BITS     = 12;
	localparam int PC_BITS       = 7;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	// Configuration reset values
	localparam logic [SW_BITS-1:0]   SW_RESET   = 4'd8;
	localparam logic [POLY_BITS-1:0] POLY_RESET = 13'd285;
	localparam logic [BASE_BITS-1:0] BASE_RESET = 12'd0;
	localparam logic [PC_BITS-1:0]   PC_RESET   = 7'd10;

	// Smallest symbol width the field arithmetic supports
	localparam int MIN_SYM_BITS = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SYMBOL_WIDTH   = 2'd0,
		CFG_FIELD_POLY     = 2'd1,
		CFG_GENERATOR_BASE = 2'd2,
		CFG_PARITY_COUNT   = 2'd3
	} cfg_reg_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		S_START = 7'b0000001,
		S_RED   = 7'b0000010,
		S_FOLD  = 7'b0000100,
		S_POW   = 7'b0001000,
		S_GEN   = 7'b0010000,
		S_DATA  = 7'b0100000,
		S_DRAIN = 7'b1000000
	} state_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic clear;   // zero generator and remainder
		logic build;   // multiply generator by (x + root)
		logic absorb;  // LFSR step with feedback symbol
		logic shift;   // move remainder one cell towards the output
	} cell_ctl_t;

endpackage

// File: sv/rspe_gfmul.sv
`timescale 1ns / 1ps
// GF(2^m) multiplier: carry-less product followed by reduction through a
// table of x^k mod p(x). Uses no package items.
module rspe_gfmul #(
	parameter int W = 12
) (
	input  logic [W-1:0]           a,
	input  logic [W-1:0]           b,
	input  logic [2*W-2:0][W-1:0]  red,
	output logic [W-1:0]           p
);

	logic [2*W-2:0] clp;

	// Carry-less partial products
	always_comb begin
		clp = '0;
		for (int i = 0; i < W; i++) begin
			for (int j = 0; j < W; j++) begin
				clp[i+j] = clp[i+j] ^ (a[i] & b[j]);
			end
		end
	end

	// Fold every product bit back into the field through its table row
	always_comb begin
		p = '0;
		for (int k = 0; k < 2*W-1; k++) begin
			if (clp[k]) begin
				p = p ^ red[k];
			end
		end
	end

endmodule

// File: sv/rspe_cell.sv
`timescale 1ns / 1ps
// One cell of the encoder chain: holds one generator coefficient and one
// remainder symbol. Depends on rspe_pkg and rspe_gfmul.
module rspe_cell #(
	parameter int W = 12
) (
	input  logic                  clk,
	input  rspe_pkg::cell_ctl_t   ctl,
	input  logic [W-1:0]          root,
	input  logic [W-1:0]          fb,
	input  logic [2*W-2:0][W-1:0] red,
	input  logic [W-1:0]          g_prev,
	input  logic [W-1:0]          rem_next,
	output logic [W-1:0]          g,
	output logic [W-1:0]          rem
);

	logic [W-1:0] g_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] op_a;
	logic [W-1:0] op_b;
	logic [W-1:0] prod;

	// One multiplier, shared between generator build and LFSR update
	assign op_a = ctl.build ? root : fb;
	assign op_b = ctl.build ? g_prev : g_q;

	rspe_gfmul #(.W(W)) u_mul (
		.a   (op_a),
		.b   (op_b),
		.red (red),
		.p   (prod)
	);

	// Coefficient and remainder registers
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			g_q   <= '0;
			rem_q <= '0;
		end else if (ctl.build) begin
			g_q <= g_q ^ prod;
		end else if (ctl.absorb) begin
			rem_q <= rem_next ^ prod;
		end else if (ctl.shift) begin
			rem_q <= rem_next;
		end
	end

	assign g   = g_q;
	assign rem = rem_q;

endmodule

// File: sv/reed_solomon_parity_encoder_top.sv
`timescale 1ns / 1ps
// Reed-Solomon systematic parity encoder over GF(2^m): sequencer, field setup
// and chain of rspe_cell. Depends on rspe_pkg, rspe_cell, rspe_gfmul.
//
// Usage
//   Input channel: data_symbol/data_last with in_valid/in_stall. One data
//   symbol is taken per cycle while a message is open; data_last closes it.
//   Output channel: parity_symbol/parity_last with out_valid/out_stall. After
//   the last data symbol the n parity symbols follow, highest order first,
//   one per cycle while out_stall is low; parity_last marks the final one.
//   Configuration: cfg_we/cfg_index/cfg_data, to be written between messages
//   (unenforced); a write with no message open restarts setup with new values.
// Sequence
//   Before each message the block builds its field tables and generator: the
//   reduction table, then the root exponent, the root power and the generator.
//   in_stall stays high meanwhile. Data symbols then go at one per cycle
//   through the cell chain. The first parity symbol is shown in the cycle after
//   data_last is taken; out_stall holds the current symbol.
// Reset
//   arst_n loads the default configuration and starts the setup sequence.
module reed_solomon_parity_encoder_top #(
	parameter int MAX_PARITY      = rspe_pkg::PARITY_DEF,
	parameter int MAX_SYMBOL_BITS = rspe_pkg::SYM_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// data input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [MAX_SYMBOL_BITS-1:0]         data_symbol,
	input  logic                               data_last,
	// parity output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [MAX_SYMBOL_BITS-1:0]         parity_symbol,
	output logic                               parity_last,
	// configuration
	input  logic                               cfg_we,
	input  logic [rspe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rspe_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int W       = MAX_SYMBOL_BITS;
	localparam int RN      = 2 * W - 1;
	localparam int XW      = rspe_pkg::BASE_BITS + 1;
	localparam int XB      = $clog2(XW);
	localparam int NW      = $clog2(MAX_PARITY + 1);
	localparam int MW      = $clog2(W + 1);
	localparam int CNT_TOP = (MAX_PARITY > RN) ? ((MAX_PARITY > XW) ? MAX_PARITY : XW)
	                                           : ((RN > XW) ? RN : XW);
	localparam int CW      = $clog2(CNT_TOP + 1);

	// Configuration registers
	logic [rspe_pkg::SW_BITS-1:0]   cfg_sw_q;
	logic [rspe_pkg::POLY_BITS-1:0] cfg_poly_q;
	logic [rspe_pkg::BASE_BITS-1:0] cfg_base_q;
	logic [rspe_pkg::PC_BITS-1:0]   cfg_pc_q;

	// Control
	rspe_pkg::state_t state_q;
	logic [CW-1:0]    cnt_q;
	logic             started_q;

	// Message field setup
	logic [MW-1:0]          m_q;
	logic [NW-1:0]          n_q;
	logic [W-1:0]           poly_q;
	logic [XW-1:0]          x_q;
	logic [W-1:0]           r_q;
	logic [RN-1:0][W-1:0]   red_q;

	logic [MW-1:0]          m_clamp;
	logic [NW-1:0]          n_clamp;
	logic [W-1:0]           mask;
	logic [XW-1:0]          mask_x;
	logic [W-1:0]           polym;
	logic [XW-1:0]          x_hi;
	logic [W-1:0]           sq;
	logic [W-1:0]           fb;
	logic                   in_acc;
	logic                   out_acc;
	logic                   cnt_last;
	logic                   restart;
	rspe_pkg::cell_ctl_t    ctl;

	logic [W-1:0] g_w    [MAX_PARITY];
	logic [W-1:0] rem_w  [MAX_PARITY];
	logic [W-1:0] gp_w   [MAX_PARITY];
	logic [W-1:0] rn_w   [MAX_PARITY];

	// Multiply by alpha (x) in the current field
	function automatic logic [W-1:0] xtime(
		input logic [W-1:0]  a,
		input logic [MW-1:0] m,
		input logic [W-1:0]  pm,
		input logic [W-1:0]  msk
	);
		logic [W:0] t;
		t = {a, 1'b0};
		xtime = (t[W-1:0] & msk) ^ (t[m] ? pm : '0);
	endfunction

	// Clamp configuration to the supported ranges
	always_comb begin
		if (32'(cfg_sw_q) < rspe_pkg::MIN_SYM_BITS) begin
			m_clamp = MW'(rspe_pkg::MIN_SYM_BITS);
		end else if (32'(cfg_sw_q) > W) begin
			m_clamp = MW'(W);
		end else begin
			m_clamp = MW'(cfg_sw_q);
		end
		if (cfg_pc_q == '0) begin
			n_clamp = NW'(1);
		end else if (32'(cfg_pc_q) > MAX_PARITY) begin
			n_clamp = NW'(MAX_PARITY);
		end else begin
			n_clamp = NW'(cfg_pc_q);
		end
	end

	assign mask   = ~({W{1'b1}} << m_q);
	assign mask_x = ~({XW{1'b1}} << m_q);
	// polynomial is latched together with m, so it is cut at the new width
	assign polym  = W'(cfg_poly_q) & ~({W{1'b1}} << m_clamp);
	assign x_hi   = x_q >> m_q;

	// Handshakes
	assign in_stall  = (state_q != rspe_pkg::S_DATA);
	assign out_valid = (state_q == rspe_pkg::S_DRAIN);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign cnt_last  = (cnt_q == CW'(n_q - NW'(1)));

	// A configuration write outside an open message redoes the setup
	assign restart = cfg_we && (state_q != rspe_pkg::S_DRAIN)
	                 && !((state_q == rspe_pkg::S_DATA) && (started_q || in_valid));

	// Configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sw_q   <= rspe_pkg::SW_RESET;
			cfg_poly_q <= rspe_pkg::POLY_RESET;
			cfg_base_q <= rspe_pkg::BASE_RESET;
			cfg_pc_q   <= rspe_pkg::PC_RESET;
		end else if (cfg_we) begin
			case (rspe_pkg::cfg_reg_t'(cfg_index))
				rspe_pkg::CFG_SYMBOL_WIDTH: begin
					cfg_sw_q <= cfg_data[rspe_pkg::SW_BITS-1:0];
				end
				rspe_pkg::CFG_FIELD_POLY: begin
					cfg_poly_q <= cfg_data[rspe_pkg::POLY_BITS-1:0];
				end
				rspe_pkg::CFG_GENERATOR_BASE: begin
					cfg_base_q <= cfg_data[rspe_pkg::BASE_BITS-1:0];
				end
				rspe_pkg::CFG_PARITY_COUNT: begin
					cfg_pc_q <= cfg_data[rspe_pkg::PC_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rspe_pkg::S_START;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else if (restart) begin
			state_q   <= rspe_pkg::S_START;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				rspe_pkg::S_START: begin
					cnt_q   <= '0;
					state_q <= rspe_pkg::S_RED;
				end
				rspe_pkg::S_RED: begin
					if (cnt_q == CW'(RN - 2)) begin
						state_q <= rspe_pkg::S_FOLD;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				rspe_pkg::S_FOLD: begin
					if (x_hi == '0) begin
						cnt_q   <= CW'(XW - 1);
						state_q <= rspe_pkg::S_POW;
					end
				end
				rspe_pkg::S_POW: begin
					if (cnt_q == '0) begin
						state_q <= rspe_pkg::S_GEN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				rspe_pkg::S_GEN: begin
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= rspe_pkg::S_DATA;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				rspe_pkg::S_DATA: begin
					if (in_acc) begin
						started_q <= 1'b1;
						if (data_last) begin
							cnt_q   <= '0;
							state_q <= rspe_pkg::S_DRAIN;
						end
					end
				end
				rspe_pkg::S_DRAIN: begin
					if (out_acc) begin
						if (cnt_last) begin
							started_q <= 1'b0;
							state_q   <= rspe_pkg::S_START;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= rspe_pkg::S_START;
				end
			endcase
		end
	end

	// Multiplier for squaring during the root power
	rspe_gfmul #(.W(W)) u_sq (
		.a   (r_q),
		.b   (r_q),
		.red (red_q),
		.p   (sq)
	);

	// Field setup: latch, reduction table, exponent fold, root power, root step
	always_ff @(posedge clk) begin
		case (state_q)
			rspe_pkg::S_START: begin
				m_q    <= m_clamp;
				n_q    <= n_clamp;
				poly_q <= polym;
				x_q    <= XW'(cfg_base_q);
				// row 0 is x^0, the rest fill in one row per cycle
				red_q  <= (RN*W)'(1);
			end
			rspe_pkg::S_RED: begin
				red_q[0] <= W'(1);
				for (int k = 1; k < RN; k++) begin
					red_q[k] <= xtime(red_q[k-1], m_q, poly_q, mask);
				end
			end
			rspe_pkg::S_FOLD: begin
				if (x_hi != '0) begin
					x_q <= (x_q & mask_x) + x_hi;
				end else begin
					// exponent of 2^m - 1 is the same root as exponent zero
					if (x_q == mask_x) begin
						x_q <= '0;
					end
					r_q <= W'(1);
				end
			end
			rspe_pkg::S_POW: begin
				r_q <= x_q[cnt_q[XB-1:0]] ? xtime(sq, m_q, poly_q, mask) : sq;
			end
			rspe_pkg::S_GEN: begin
				r_q <= xtime(r_q, m_q, poly_q, mask);
			end
			default: begin
			end
		endcase
	end

	// Cell commands and feedback
	assign ctl.clear  = (state_q == rspe_pkg::S_START);
	assign ctl.build  = (state_q == rspe_pkg::S_GEN);
	assign ctl.absorb = in_acc;
	assign ctl.shift  = out_acc;
	assign fb         = (data_symbol & mask) ^ rem_w[0];

	// Chain of cells, highest-order generator coefficient nearest the output
	for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign gp_w[i] = W'(1);
		end else begin : g_body
			assign gp_w[i] = g_w[i-1];
		end
		if (i == MAX_PARITY - 1) begin : g_tail
			assign rn_w[i] = '0;
		end else begin : g_link
			assign rn_w[i] = rem_w[i+1];
		end

		rspe_cell #(.W(W)) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.root     (r_q),
			.fb       (fb),
			.red      (red_q),
			.g_prev   (gp_w[i]),
			.rem_next (rn_w[i]),
			.g        (g_w[i]),
			.rem      (rem_w[i])
		);
	end

	assign parity_symbol = rem_w[0];
	assign parity_last   = cnt_last;

endmodule

// File: sv/rspe_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the parity encoder top level, bound to it below.
// Depends on reed_solomon_parity_encoder_top.
module rspe_checker #(
	parameter int MAX_SYMBOL_BITS = 12
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       data_last,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [MAX_SYMBOL_BITS-1:0] parity_symbol,
	input logic                       parity_last
);

	// No data transaction is taken while parity is being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
	else $error("input open while parity drains");

	// Closing a message starts parity delivery on the next cycle
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && data_last) |=> out_valid)
	else $error("parity missing after last data symbol");

	// The final parity transaction ends delivery
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && parity_last) |=> !out_valid)
	else $error("parity continues after last symbol");

	// A stalled parity symbol holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(parity_symbol) && $stable(parity_last)))
	else $error("stalled parity changed");

endmodule

bind reed_solomon_parity_encoder_top rspe_checker #(
	.MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)
) u_rspe_checker (.*);
